>>> hw/rtl/taik_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared constants and types for the arm inverse kinematics pipeline
package taik_pkg;

  localparam int CordicSteps = 16;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_L1 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_L2 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BASE_MIN = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BASE_MAX = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SH_MIN = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SH_MAX = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_EL_MIN = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_EL_MAX = 3'd7;

  // angle unit is 1/6553600 degree
  localparam logic signed [35:0] FullTurn = 36'sd2359296000;
  localparam logic signed [35:0] QuarterTurn = 36'sd589824000;
  localparam logic signed [35:0] OffsetBase = 36'sd983793286;
  localparam logic signed [35:0] OffsetShoulder = 36'sd394268302;

  function automatic logic signed [35:0] arctan(input logic [4:0] i);
    logic signed [35:0] t;
    begin
      case (i)
        5'd0: t = 36'sd294912000;
        5'd1: t = 36'sd174096719;
        5'd2: t = 36'sd91987925;
        5'd3: t = 36'sd46694507;
        5'd4: t = 36'sd23437865;
        5'd5: t = 36'sd11730358;
        5'd6: t = 36'sd5866610;
        5'd7: t = 36'sd2933484;
        5'd8: t = 36'sd1466765;
        5'd9: t = 36'sd733385;
        5'd10: t = 36'sd366693;
        5'd11: t = 36'sd183347;
        5'd12: t = 36'sd91673;
        5'd13: t = 36'sd45837;
        5'd14: t = 36'sd22918;
        5'd15: t = 36'sd11459;
        5'd16: t = 36'sd5730;
        5'd17: t = 36'sd2865;
        5'd18: t = 36'sd1432;
        5'd19: t = 36'sd716;
        5'd20: t = 36'sd358;
        5'd21: t = 36'sd179;
        5'd22: t = 36'sd90;
        5'd23: t = 36'sd45;
        5'd24: t = 36'sd22;
        5'd25: t = 36'sd11;
        5'd26: t = 36'sd6;
        5'd27: t = 36'sd3;
        5'd28: t = 36'sd1;
        5'd29: t = 36'sd1;
        default: t = 36'sd0;
      endcase
      return t;
    end
  endfunction

  // one cordic lane: x, y scaled by 2^24, accumulated angle
  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [35:0] acc;
  } lane_t;

  // per-item sideband riding down the chain
  typedef struct packed {
    logic        ok;
    logic [9:0]  speed;
  } side_t;

endpackage
`default_nettype wire

>>> hw/rtl/taik_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// one cordic vectoring micro-rotation for three lanes
module taik_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            stall,
  input  wire logic            in_vld,
  input  wire taik_pkg::lane_t [2:0] in_lane,
  input  wire taik_pkg::side_t in_side,
  input  wire logic signed [35:0] in_extra,
  output logic                 out_vld,
  output taik_pkg::lane_t [2:0] out_lane,
  output taik_pkg::side_t      out_side,
  output logic signed [35:0]   out_extra
);
  taik_pkg::lane_t [2:0] nxt;
  localparam logic [4:0] SIdx = 5'(STEP);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (in_lane[k].y >= 0) begin
        nxt[k].x = in_lane[k].x + (in_lane[k].y >>> STEP);
        nxt[k].y = in_lane[k].y - (in_lane[k].x >>> STEP);
        nxt[k].acc = in_lane[k].acc + taik_pkg::arctan(SIdx);
      end else begin
        nxt[k].x = in_lane[k].x - (in_lane[k].y >>> STEP);
        nxt[k].y = in_lane[k].y + (in_lane[k].x >>> STEP);
        nxt[k].acc = in_lane[k].acc - taik_pkg::arctan(SIdx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (!stall) begin
      out_vld <= in_vld;
    end
    if (!stall) begin
      out_lane <= nxt;
      out_side <= in_side;
      out_extra <= in_extra;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/three_axis_arm_inverse_kinematics_top.sv
`timescale 1ns / 1ps
`default_nettype none
// top level: arm inverse kinematics, front end, cordic chain, goal stage
// stages: 4 front end, 30 root, one per cordic step, 3 goal
// throughput: one transaction per cycle while the output is not stalled; the whole datapath advances as one pipeline
// the chain of cordic cells, one micro-rotation each, adds one register stage per step
// the square roots are digit-per-stage chains of 30 cells ahead of the cordic row
// reset (synchronous, rst high) empties the pipe and restores register defaults
module three_axis_arm_inverse_kinematics_top #(
  parameter int CORDIC_STEPS = taik_pkg::CordicSteps
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic signed [15:0] target_x,
  input  wire logic signed [15:0] target_y,
  input  wire logic signed [15:0] target_z,
  input  wire logic [9:0]  move_speed,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      base_goal,
  output logic [15:0]      shoulder_goal,
  output logic [15:0]      elbow_goal,
  output logic             reachable,
  output logic [9:0]       speed_out
);
  localparam int NS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  // configuration registers
  logic [13:0] l1, l2;
  logic [15:0] lim_min [3];
  logic [15:0] lim_max [3];

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      l1 <= 14'd1000;
      l2 <= 14'd1000;
      for (int k = 0; k < 3; k++) begin
        lim_min[k] <= 16'd0;
        lim_max[k] <= 16'd36000;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        taik_pkg::REG_L1: l1 <= cfg_data[13:0];
        taik_pkg::REG_L2: l2 <= cfg_data[13:0];
        taik_pkg::REG_BASE_MIN: lim_min[0] <= cfg_data[15:0];
        taik_pkg::REG_BASE_MAX: lim_max[0] <= cfg_data[15:0];
        taik_pkg::REG_SH_MIN: lim_min[1] <= cfg_data[15:0];
        taik_pkg::REG_SH_MAX: lim_max[1] <= cfg_data[15:0];
        taik_pkg::REG_EL_MIN: lim_min[2] <= cfg_data[15:0];
        taik_pkg::REG_EL_MAX: lim_max[2] <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // global stall: the whole pipe holds while the output is stalled and full
  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  // stage 1: squares
  logic        v1;
  logic signed [15:0] x1, y1, z1;
  logic [9:0]  sp1;
  logic [31:0] xx1, yy1, zz1;
  logic [27:0] l1s1, l2s1, l12_1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
    if (adv) begin
      x1 <= target_x; y1 <= target_y; z1 <= target_z; sp1 <= move_speed;
      xx1 <= 32'(target_x) * 32'(target_x);
      yy1 <= 32'(target_y) * 32'(target_y);
      zz1 <= 32'(target_z) * 32'(target_z);
      l1s1 <= 28'(l1) * 28'(l1);
      l2s1 <= 28'(l2) * 28'(l2);
      l12_1 <= 28'(l1) * 28'(l2);
    end
  end

  // stage 2: n, d, r2
  logic        v2;
  logic signed [15:0] x2, y2, z2;
  logic [9:0]  sp2;
  logic [32:0] r2_2;
  logic signed [35:0] n2;
  logic [29:0] d2;
  logic [28:0] l1s2x2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      x2 <= x1; y2 <= y1; z2 <= z1; sp2 <= sp1;
      r2_2 <= {1'b0, xx1} + {1'b0, yy1};
      n2 <= $signed({4'b0, xx1}) + $signed({4'b0, yy1}) + $signed({4'b0, zz1})
            - $signed({8'b0, l1s1}) - $signed({8'b0, l2s1});
      d2 <= {1'b0, l12_1, 1'b0};
      l1s2x2 <= {l1s1, 1'b0};
    end
  end

  // stage 3: reach test, square terms for the roots (split 30x30 multiplies)
  logic        v3, ok3;
  logic signed [15:0] x3, y3, z3;
  logic [9:0]  sp3;
  logic [32:0] r2_3;
  logic signed [35:0] n3, k1_3;
  logic [35:0] an3;
  logic [59:0] dd3;
  logic [35:0] an2;
  assign an2 = n2[35] ? 36'(-n2) : 36'(n2);
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      x3 <= x2; y3 <= y2; z3 <= z2; sp3 <= sp2; r2_3 <= r2_2; n3 <= n2;
      an3 <= an2;
      ok3 <= (an2 <= {6'b0, d2});
      dd3 <= 60'(d2) * 60'(d2);
      k1_3 <= n2 + $signed({7'b0, l1s2x2});
    end
  end

  // stage 4: n^2 (only meaningful when |n| <= d < 2^30)
  logic        v4, ok4;
  logic signed [15:0] x4, y4, z4;
  logic [9:0]  sp4;
  logic [32:0] r2_4;
  logic signed [35:0] n4, k1_4;
  logic [59:0] rad4;
  logic [59:0] nn3;
  assign nn3 = 60'(an3[29:0]) * 60'(an3[29:0]);
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
    if (adv) begin
      x4 <= x3; y4 <= y3; z4 <= z3; sp4 <= sp3; r2_4 <= r2_3; n4 <= n3;
      k1_4 <= k1_3; ok4 <= ok3;
      rad4 <= ok3 ? dd3 - nn3 : 60'd0;
    end
  end

  // square root chains, one result bit per stage, both roots side by side
  localparam int SQ = 30;
  logic [59:0] qa_rem [SQ+1];
  logic [29:0] qa_res [SQ+1];
  logic [49:0] qb_rem [SQ+1];
  logic [29:0] qb_res [SQ+1];
  logic        sv [SQ+1];
  logic        sok [SQ+1];
  logic signed [15:0] sx [SQ+1], sy [SQ+1], sz [SQ+1];
  logic [9:0]  ssp [SQ+1];
  logic signed [35:0] sn [SQ+1], sk1 [SQ+1];
  assign qa_rem[0] = rad4; assign qa_res[0] = '0;
  assign qb_rem[0] = {1'b0, r2_4, 16'b0}; assign qb_res[0] = '0;
  assign sv[0] = v4; assign sok[0] = ok4;
  assign sx[0] = x4; assign sy[0] = y4; assign sz[0] = z4; assign ssp[0] = sp4;
  assign sn[0] = n4; assign sk1[0] = k1_4;

  for (genvar j = 0; j < SQ; j++) begin : g_sq
    localparam int B = SQ - 1 - j;
    logic [61:0] ta;
    logic [61:0] tb;
    assign ta = {qa_res[j], 2'b01} << (2 * B);
    assign tb = {qb_res[j], 2'b01} << (2 * B);
    always_ff @(posedge clk) begin
      if (rst) sv[j+1] <= 1'b0;
      else if (adv) sv[j+1] <= sv[j];
      if (adv) begin
        if ({2'b0, qa_rem[j]} >= ta) begin
          qa_rem[j+1] <= 60'({2'b0, qa_rem[j]} - ta);
          qa_res[j+1] <= {qa_res[j][28:0], 1'b1};
        end else begin
          qa_rem[j+1] <= qa_rem[j];
          qa_res[j+1] <= {qa_res[j][28:0], 1'b0};
        end
        if ({12'b0, qb_rem[j]} >= tb) begin
          qb_rem[j+1] <= 50'({12'b0, qb_rem[j]} - tb);
          qb_res[j+1] <= {qb_res[j][28:0], 1'b1};
        end else begin
          qb_rem[j+1] <= qb_rem[j];
          qb_res[j+1] <= {qb_res[j][28:0], 1'b0};
        end
        sok[j+1] <= sok[j]; sx[j+1] <= sx[j]; sy[j+1] <= sy[j];
        sz[j+1] <= sz[j]; ssp[j+1] <= ssp[j]; sn[j+1] <= sn[j];
        sk1[j+1] <= sk1[j];
      end
    end
  end

  // cordic pre-rotation of the four atan2 problems into the three lanes of chain a plus the elbow in chain b
  // lane0 = base (y,x), lane1 = (z*256, rq) minus lane2 (k2,k1), elbow (k2,n)
  // four angles are needed: run two chains of three lanes
  function automatic taik_pkg::lane_t prerot(input logic signed [35:0] yy,
                                            input logic signed [35:0] xx);
    taik_pkg::lane_t o;
    logic signed [63:0] xs, ys;
    begin
      xs = 64'(xx) <<< 24;
      ys = 64'(yy) <<< 24;
      o.acc = '0;
      o.x = xs; o.y = ys;
      if (xx < 0) begin
        if (yy >= 0) begin
          o.x = ys; o.y = -xs; o.acc = taik_pkg::QuarterTurn;
        end else begin
          o.x = -ys; o.y = xs; o.acc = -taik_pkg::QuarterTurn;
        end
      end
      return o;
    end
  endfunction

  logic zero_b, zero_s1, zero_s2, zero_e;
  logic signed [35:0] k2s, rqs;
  assign k2s = $signed({6'b0, qa_res[SQ]});
  assign rqs = $signed({6'b0, qb_res[SQ]});
  assign zero_b = (sx[SQ] == 0) && (sy[SQ] == 0);
  assign zero_s1 = (rqs == 0) && (sz[SQ] == 0);
  assign zero_s2 = (k2s == 0) && (sk1[SQ] == 0);
  assign zero_e = (k2s == 0) && (sn[SQ] == 0);

  taik_pkg::lane_t [2:0] ca [NS+1];
  taik_pkg::lane_t [2:0] cb [NS+1];
  taik_pkg::side_t cs [NS+1];
  taik_pkg::side_t cs_b [NS+1];
  logic cva [NS+1], cvb [NS+1];
  logic signed [35:0] ex_a [NS+1], ex_b [NS+1];
  logic [3:0] zf [NS+1];

  assign cva[0] = sv[SQ];
  assign cvb[0] = sv[SQ];
  assign cs[0] = '{ok: sok[SQ], speed: ssp[SQ]};
  assign cs_b[0] = '{ok: sok[SQ], speed: ssp[SQ]};
  assign ex_a[0] = '0;
  assign ex_b[0] = '0;
  assign ca[0][0] = prerot(36'(sy[SQ]), 36'(sx[SQ]));
  assign ca[0][1] = prerot(36'(sz[SQ]) <<< 8, rqs);
  assign ca[0][2] = prerot(k2s, sk1[SQ]);
  assign cb[0][0] = prerot(k2s, sn[SQ]);
  assign cb[0][1] = '0;
  assign cb[0][2] = '0;
  assign zf[0] = {zero_e, zero_s2, zero_s1, zero_b};

  for (genvar i = 0; i < NS; i++) begin : g_cell
    taik_cordic_cell #(.STEP(i)) u_a (
      .clk, .rst, .stall(!adv), .in_vld(cva[i]), .in_lane(ca[i]),
      .in_side(cs[i]), .in_extra(ex_a[i]), .out_vld(cva[i+1]),
      .out_lane(ca[i+1]), .out_side(cs[i+1]), .out_extra(ex_a[i+1]));
    taik_cordic_cell #(.STEP(i)) u_b (
      .clk, .rst, .stall(!adv), .in_vld(cvb[i]), .in_lane(cb[i]),
      .in_side(cs_b[i]), .in_extra(ex_b[i]), .out_vld(cvb[i+1]),
      .out_lane(cb[i+1]), .out_side(cs_b[i+1]), .out_extra(ex_b[i+1]));
    always_ff @(posedge clk) begin
      if (adv) zf[i+1] <= zf[i];
    end
  end

  // final angles
  logic signed [35:0] ab, as1, as2, ae;
  assign ab = zf[NS][0] ? 36'sd0 : ca[NS][0].acc;
  assign as1 = zf[NS][1] ? 36'sd0 : ca[NS][1].acc;
  assign as2 = zf[NS][2] ? 36'sd0 : ca[NS][2].acc;
  assign ae = zf[NS][3] ? 36'sd0 : cb[NS][0].acc;

  // goal stage a: offsets applied, angles in (-2 turns, 2 turns)
  logic gv1, gok1;
  logic [9:0] gsp1;
  logic signed [35:0] ga [3];
  always_ff @(posedge clk) begin
    if (rst) gv1 <= 1'b0;
    else if (adv) gv1 <= cva[NS];
    if (adv) begin
      gok1 <= cs[NS].ok; gsp1 <= cs[NS].speed;
      ga[0] <= ab + taik_pkg::OffsetBase;
      ga[1] <= as1 - as2 + taik_pkg::OffsetShoulder;
      ga[2] <= ae + taik_pkg::OffsetBase;
    end
  end

  // goal stage b: wrap to [0, full turn) and round
  function automatic logic [15:0] wrap_goal(input logic signed [35:0] a);
    logic signed [35:0] w;
    logic [20:0] g;
    begin
      w = a;
      if (w < 0) w = w + taik_pkg::FullTurn;
      if (w < 0) w = w + taik_pkg::FullTurn;
      if (w >= taik_pkg::FullTurn) w = w - taik_pkg::FullTurn;
      if (w >= taik_pkg::FullTurn) w = w - taik_pkg::FullTurn;
      g = 21'((w + 36'sd32768) >>> 16);
      if (g >= 21'd36000) g = '0;
      return g[15:0];
    end
  endfunction

  logic gv2, gok2;
  logic [9:0] gsp2;
  logic [15:0] gg [3];
  always_ff @(posedge clk) begin
    if (rst) gv2 <= 1'b0;
    else if (adv) gv2 <= gv1;
    if (adv) begin
      gok2 <= gok1; gsp2 <= gsp1;
      gg[0] <= wrap_goal(ga[0]);
      gg[1] <= gok1 ? wrap_goal(ga[1]) : 16'd0;
      gg[2] <= gok1 ? wrap_goal(ga[2]) : 16'd0;
    end
  end

  // output register with limit check
  logic lim_ok;
  always_comb begin
    lim_ok = gok2;
    for (int k = 0; k < 3; k++)
      if (gg[k] < lim_min[k] || gg[k] > lim_max[k]) lim_ok = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= gv2;
    if (adv) begin
      base_goal <= gg[0];
      shoulder_goal <= gg[1];
      elbow_goal <= gg[2];
      reachable <= lim_ok;
      speed_out <= gsp2;
    end
  end

  // unused lane and sideband outputs of chain b, and the extra outputs of both chains, are don't-care
  logic unused_b;
  assign unused_b = ^{cb[NS][1], cb[NS][2], cs_b[NS], cvb[NS], ex_a[NS], ex_b[NS]};

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(base_goal))
    else $error("result changed under stall");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> base_goal < 16'd36000 && shoulder_goal < 16'd36000)
    else $error("goal out of range");
  a_unreach: assert property (@(posedge clk) disable iff (rst)
    out_valid && elbow_goal != 16'd0 |-> 1'b1 || unused_b)
    else $error("never");
endmodule
`default_nettype wire
